>>> hdl/gwm_pkg.sv
package gwm_pkg;

   localparam int CHAR_W       = 8;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_LENGTH_W = 6;
   localparam int CSR_LANES    = CSR_DATA_W / CHAR_W;

   localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
   localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_A = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_B = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_C = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_D = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH    = 3'd4;

   typedef struct packed {
      logic advance;
      logic rearm;
   } gwm_ctrl_type;

   typedef struct packed {
      logic carry;
      logic step;
      logic fin_carry;
   } gwm_link_type;

endpackage

>>> hdl/gwm_cell.sv
module gwm_cell #(
   parameter bit START = 1'b0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gwm_pkg::gwm_ctrl_type           ctrl,
   input  logic [gwm_pkg::CHAR_W-1:0]      subject_char,
   input  logic [gwm_pkg::CHAR_W-1:0]      pattern_char,
   input  logic                            live,
   input  logic                            keep,
   input  gwm_pkg::gwm_link_type           link_in,
   output gwm_pkg::gwm_link_type           link_out,
   output logic                            fin_closed
);
   import gwm_pkg::*;

   logic active_ff;
   logic active_in;
   logic final_ff;
   logic final_in;
   logic closed;
   logic is_star;
   logic is_match;
   logic next_bit;

   assign closed   = (active_ff & keep) | link_in.carry;
   assign is_star  = live & (pattern_char == STAR_CHAR);
   assign is_match = live & (pattern_char != STAR_CHAR)
                     & ((pattern_char == ANY_CHAR) | (pattern_char == subject_char));
   assign next_bit = (closed & is_star) | link_in.step;

   assign fin_closed = (final_ff & keep) | link_in.fin_carry;

   assign link_out.carry     = closed & is_star;
   assign link_out.step      = closed & is_match;
   assign link_out.fin_carry = fin_closed & is_star;

   always_comb begin
      final_in = ctrl.advance ? next_bit : active_ff;
      priority if (ctrl.rearm) begin
         active_in = START;
      end else if (ctrl.advance) begin
         active_in = next_bit;
      end else begin
         active_in = active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= START;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rearm) begin
         final_ff <= final_in;
      end
   end

endmodule

>>> hdl/gwm_cfg.sv
module gwm_cfg #(
   parameter int PATTERN_MAX = 32,
   parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gwm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gwm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic [PATTERN_MAX*gwm_pkg::CHAR_W-1:0] pattern_chars,
   output logic [LEN_W-1:0]                    len_eff
);
   import gwm_pkg::*;

   localparam logic [CSR_LENGTH_W-1:0] LEN_CAP = CSR_LENGTH_W'(PATTERN_MAX);

   logic [CSR_LENGTH_W-1:0] length_ff;
   logic [CSR_LENGTH_W-1:0] length_in;
   logic                    write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid & csr_ready;

   genvar j;
   generate
      for (j = 0; j < PATTERN_MAX; j++) begin : g_byte
         localparam logic [CSR_INDEX_W-1:0] REG_INDEX =
            CSR_PATTERN_A + CSR_INDEX_W'(j / CSR_LANES);
         localparam int LANE = j % CSR_LANES;
         logic [CHAR_W-1:0] char_ff;
         logic [CHAR_W-1:0] char_in;

         assign char_in = (write && csr_index == REG_INDEX)
                          ? csr_wdata[LANE*CHAR_W +: CHAR_W] : char_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               char_ff <= '0;
            end else begin
               char_ff <= char_in;
            end
         end

         assign pattern_chars[j*CHAR_W +: CHAR_W] = char_ff;
      end
   endgenerate

   assign length_in = (write && csr_index == CSR_LENGTH)
                      ? csr_wdata[CSR_LENGTH_W-1:0] : length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else begin
         length_ff <= length_in;
      end
   end

   assign len_eff = (length_ff > LEN_CAP) ? LEN_W'(PATTERN_MAX) : length_ff[LEN_W-1:0];

endmodule

>>> hdl/glob_wildcard_matcher.sv
// Result: the last item's final state is held, then registered out when the output is free.
// Throughput: one subject byte per cycle while not stalled; the cell row updates on advance.
// Closure runs along the cell row and again on the held final state in the output stage.
// Reset: synchronous, active high; pattern registers and length clear to 0, start position
// active, no result pending.
module glob_wildcard_matcher #(
   parameter int PATTERN_MAX = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [gwm_pkg::CHAR_W-1:0]           req_subject_char,
   input  logic                                 req_last_char,
   input  logic                                 req_no_char,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_matched,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gwm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gwm_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import gwm_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   logic [PATTERN_MAX*CHAR_W-1:0] pattern_chars;
   logic [LEN_W-1:0]              len_eff;
   gwm_ctrl_type                  ctrl;
   gwm_link_type                  links [0:PATTERN_MAX+1];
   logic [PATTERN_MAX:0]          fin_bits;
   logic                          accept;
   logic                          out_load;
   logic                          held_ff;
   logic                          held_in;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic                          matched_ff;
   logic                          matched_in;

   gwm_cfg #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_W       (LEN_W)
   ) u_cfg (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .pattern_chars (pattern_chars),
      .len_eff       (len_eff)
   );

   assign out_load  = ~out_valid_ff | ~rsp_stall;
   assign req_stall = held_ff & ~out_load;
   assign accept    = req_valid & ~req_stall;

   assign ctrl.advance = accept & ~req_no_char;
   assign ctrl.rearm   = accept & req_last_char;

   assign links[0] = '0;

   genvar k;
   generate
      for (k = 0; k <= PATTERN_MAX; k++) begin : g_cell
         localparam logic [LEN_W-1:0] POS = LEN_W'(k);
         logic [CHAR_W-1:0] cell_char;

         if (k < PATTERN_MAX) begin : g_char
            assign cell_char = pattern_chars[k*CHAR_W +: CHAR_W];
         end else begin : g_tail
            assign cell_char = '0;
         end

         gwm_cell #(
            .START (k == 0)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (ctrl),
            .subject_char (req_subject_char),
            .pattern_char (cell_char),
            .live         (POS < len_eff),
            .keep         (POS <= len_eff),
            .link_in      (links[k]),
            .link_out     (links[k+1]),
            .fin_closed   (fin_bits[k])
         );
      end
   endgenerate

   always_comb begin
      priority if (ctrl.rearm) begin
         held_in = 1'b1;
      end else if (out_load) begin
         held_in = 1'b0;
      end else begin
         held_in = held_ff;
      end
      out_valid_in = out_load ? held_ff : out_valid_ff;
      matched_in   = out_load ? fin_bits[len_eff] : matched_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_matched = matched_ff;

endmodule
